// ===== rtl/gce_pkg.sv =====
// Shared types, constants and colour unpacking for the graphics command engine
`default_nettype none
package gce_pkg;
	localparam int SCREEN_WIDTH  = 300;
	localparam int SCREEN_ROWS   = 216;
	localparam int VIEW_WIDTH    = 288;
	localparam int VIEW_HEIGHT   = 192;
	localparam int FB_DEPTH      = SCREEN_WIDTH * SCREEN_ROWS;
	localparam int FB_AW         = $clog2(FB_DEPTH);
	localparam int XW            = $clog2(SCREEN_WIDTH);
	localparam int YW            = $clog2(SCREEN_ROWS);
	localparam int BORDER_W      = (VIEW_WIDTH < SCREEN_WIDTH) ?
		(SCREEN_WIDTH - VIEW_WIDTH) / 2 : 0;
	localparam int BORDER_H      = (VIEW_HEIGHT < SCREEN_ROWS) ?
		(SCREEN_ROWS - VIEW_HEIGHT) / 2 : 0;
	localparam int QDEPTH        = 2;

	typedef enum logic [3:0] {
		OP_NOP = 4'd0, OP_PRESET = 4'd1, OP_BORDER = 4'd2, OP_TILE = 4'd3,
		OP_TILE_XOR = 4'd4, OP_LOAD = 4'd5, OP_SCROLL = 4'd6, OP_TRANS = 4'd7,
		OP_READ = 4'd8
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0, ST_BAD_OP = 2'd1, ST_OFF_SCREEN = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		DIR_HOLD = 2'd0, DIR_RIGHT = 2'd1, DIR_LEFT = 2'd2, DIR_HOLD_ALT = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		K_QUICK, K_FILL, K_BORDER, K_TILE, K_SCROLL_R, K_SCROLL_L, K_READ
	} kind_t;

	typedef enum logic [2:0] {
		B_IDLE, B_RD, B_WR, B_READWAIT, B_OUT
	} bstate_t;

	// Classified command as it travels from front to back
	typedef struct packed {
		kind_t       kind;
		logic        xor_mode;
		logic [1:0]  status;
		logic [3:0]  color_a;
		logic [3:0]  color_b;
		logic [XW-1:0] x0;
		logic [YW-1:0] y0;
		logic [71:0] bits;
		logic        pal_we;
		logic [3:0]  pal_idx;
		logic [11:0] pal_rgb;
		logic        trans_we;
		logic        rd_ok;
		logic [XW-1:0] rd_x;
		logic [YW-1:0] rd_y;
	} cmd_t;

	function automatic logic [11:0] unpack_color(input logic [15:0] w);
		logic [15:0] d;
		d = w & 16'h3F3F;
		return {d[13:10], d[9:8], d[5:4], d[3:0]};
	endfunction
endpackage
`default_nettype wire

// ===== rtl/cdg_graphics_command_engine_top.sv =====
// Nop, load colour, transparent, bad op, off-screen tile and non-moving scroll go straight
// to the result; read passes through the read and read-wait states first.
// Tile walks its 12x6 pixels, presets and scroll every pixel of the frame buffer, each
// pixel taking a read state and a write state, set by the single-port frame buffer;
// one command executes at a time, a two-entry queue in front.
// Reset clears control and the transparent index; buffer and palette undefined.
`default_nettype none
module cdg_graphics_command_engine_top (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic [3:0]  opcode,
	input  wire logic [3:0]  color_a,
	input  wire logic [3:0]  color_b,
	input  wire logic [4:0]  tile_row,
	input  wire logic [5:0]  tile_col,
	input  wire logic [35:0] tile_bits_top,
	input  wire logic [35:0] tile_bits_bottom,
	input  wire logic [1:0]  scroll_dir,
	input  wire logic [3:0]  palette_index,
	input  wire logic [15:0] color_word,
	input  wire logic [8:0]  read_x,
	input  wire logic [7:0]  read_y,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic [1:0] status,
	output logic [3:0] pixel_color,
	output logic [3:0] palette_red,
	output logic [3:0] palette_green,
	output logic [3:0] palette_blue,
	output logic [3:0] transparent_index
);
	logic q_valid, q_pop;
	gce_pkg::cmd_t q_cmd;

	gce_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .opcode, .color_a, .color_b,
		.tile_row, .tile_col, .tile_bits_top, .tile_bits_bottom, .scroll_dir,
		.palette_index, .color_word, .read_x, .read_y,
		.q_valid, .q_pop, .q_cmd
	);

	gce_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_cmd, .out_valid, .out_ready,
		.status, .pixel_color, .palette_red, .palette_green, .palette_blue,
		.transparent_index
	);
endmodule
`default_nettype wire

// ===== rtl/gce_front.sv =====
// Front end: accepts commands, checks them and queues them for execution
`default_nettype none
module gce_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic [3:0]  opcode,
	input  wire logic [3:0]  color_a,
	input  wire logic [3:0]  color_b,
	input  wire logic [4:0]  tile_row,
	input  wire logic [5:0]  tile_col,
	input  wire logic [35:0] tile_bits_top,
	input  wire logic [35:0] tile_bits_bottom,
	input  wire logic [1:0]  scroll_dir,
	input  wire logic [3:0]  palette_index,
	input  wire logic [15:0] color_word,
	input  wire logic [8:0]  read_x,
	input  wire logic [7:0]  read_y,
	output logic      q_valid,
	input  wire logic q_pop,
	output gce_pkg::cmd_t q_cmd
);
	gce_pkg::cmd_t c;
	gce_pkg::cmd_t q_mem_q [gce_pkg::QDEPTH];
	logic [$clog2(gce_pkg::QDEPTH):0] cnt_q;
	logic rp_q, wp_q;
	logic [10:0] x0w, y0w;
	logic push;

	always_comb begin
		x0w = 11'(tile_col) * 11'd6;
		y0w = 11'(tile_row) * 11'd12;
		c = '0;
		c.kind = gce_pkg::K_QUICK;
		c.status = gce_pkg::ST_DONE;
		c.color_a = color_a;
		c.color_b = color_b;
		c.x0 = gce_pkg::XW'(x0w);
		c.y0 = gce_pkg::YW'(y0w);
		c.bits = {tile_bits_top, tile_bits_bottom};
		c.pal_idx = palette_index;
		c.pal_rgb = gce_pkg::unpack_color(color_word);
		c.rd_ok = (32'(read_x) < gce_pkg::SCREEN_WIDTH) &&
			(32'(read_y) < gce_pkg::SCREEN_ROWS);
		c.rd_x = gce_pkg::XW'(read_x);
		c.rd_y = gce_pkg::YW'(read_y);
		case (opcode)
			gce_pkg::OP_NOP: ;
			gce_pkg::OP_PRESET: c.kind = gce_pkg::K_FILL;
			gce_pkg::OP_BORDER: c.kind = gce_pkg::K_BORDER;
			gce_pkg::OP_TILE, gce_pkg::OP_TILE_XOR: begin
				c.xor_mode = (opcode == gce_pkg::OP_TILE_XOR);
				if (32'(x0w) + 6 > gce_pkg::SCREEN_WIDTH ||
					32'(y0w) + 12 > gce_pkg::SCREEN_ROWS)
					c.status = gce_pkg::ST_OFF_SCREEN;
				else
					c.kind = gce_pkg::K_TILE;
			end
			gce_pkg::OP_LOAD: c.pal_we = 1'b1;
			gce_pkg::OP_SCROLL: begin
				if (scroll_dir == gce_pkg::DIR_RIGHT) c.kind = gce_pkg::K_SCROLL_R;
				else if (scroll_dir == gce_pkg::DIR_LEFT) c.kind = gce_pkg::K_SCROLL_L;
			end
			gce_pkg::OP_TRANS: c.trans_we = 1'b1;
			gce_pkg::OP_READ: c.kind = gce_pkg::K_READ;
			default: c.status = gce_pkg::ST_BAD_OP;
		endcase
	end

	assign in_ready = (cnt_q != ($clog2(gce_pkg::QDEPTH)+1)'(gce_pkg::QDEPTH));
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != '0);
	assign q_cmd = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rp_q <= 1'b0;
			wp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + ($clog2(gce_pkg::QDEPTH)+1)'(push)
				- ($clog2(gce_pkg::QDEPTH)+1)'(q_pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == ($clog2(gce_pkg::QDEPTH)+1)'(gce_pkg::QDEPTH) |-> !push)
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue underflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("count not advanced");
`endif
endmodule
`default_nettype wire

// ===== rtl/gce_back.sv =====
// Back end: executes commands against frame buffer, palette and transparent index
`default_nettype none
module gce_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	output logic      q_pop,
	input  wire gce_pkg::cmd_t q_cmd,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic [1:0] status,
	output logic [3:0] pixel_color,
	output logic [3:0] palette_red,
	output logic [3:0] palette_green,
	output logic [3:0] palette_blue,
	output logic [3:0] transparent_index
);
	localparam int W = gce_pkg::SCREEN_WIDTH;
	localparam int H = gce_pkg::SCREEN_ROWS;
	localparam int XWL = gce_pkg::XW;

	gce_pkg::bstate_t st_q, st_d;
	gce_pkg::cmd_t cmd_q;
	logic [3:0] fb_mem [gce_pkg::FB_DEPTH];
	logic [11:0] pal_mem [16];
	logic [11:0] pal_rd_q;
	logic [3:0] fb_rd_q;
	logic [XWL-1:0] x_q;
	logic [gce_pkg::YW-1:0] y_q;
	logic [3:0] l_q;
	logic [2:0] j_q;
	logic [gce_pkg::FB_AW-1:0] row_base_q;

	logic take, fb_re, fb_we, last_px;
	logic [gce_pkg::FB_AW-1:0] rd_addr, wr_addr;
	logic [3:0] wr_data;
	logic [XWL-1:0] cx, sx;
	logic [gce_pkg::YW-1:0] cy;
	logic tbit, in_border, need_read;
	logic [3:0] tile_c;
	logic [6:0] bit_ix;
	logic [1:0] st_r;
	logic [3:0] pix_r;
	logic [11:0] pal_r;
	logic [3:0] trans_q;

	// pixel under the sweep: tile walks 12x6 relative to origin, others whole screen
	always_comb begin
		if (cmd_q.kind == gce_pkg::K_TILE) begin
			cx = cmd_q.x0 + XWL'(j_q);
			cy = cmd_q.y0 + gce_pkg::YW'(l_q);
		end else if (cmd_q.kind == gce_pkg::K_SCROLL_R) begin
			cx = XWL'(W - 1) - x_q;
			cy = y_q;
		end else begin
			cx = x_q;
			cy = y_q;
		end
		bit_ix = 7'd71 - (7'(l_q) * 7'd6 + 7'(j_q));
		tbit = cmd_q.bits[bit_ix];
		tile_c = tbit ? cmd_q.color_b : cmd_q.color_a;
		in_border = (32'(cx) < gce_pkg::BORDER_W) ||
			(32'(cx) >= W - gce_pkg::BORDER_W) ||
			(32'(cy) < gce_pkg::BORDER_H) || (32'(cy) >= H - gce_pkg::BORDER_H);
		// scroll source column, valid only away from the fill strip
		if (cmd_q.kind == gce_pkg::K_SCROLL_R) sx = cx - XWL'(6);
		else sx = cx + XWL'(6);
		need_read = 1'b0;
		case (cmd_q.kind)
			gce_pkg::K_TILE: need_read = cmd_q.xor_mode;
			gce_pkg::K_SCROLL_R: need_read = (32'(cx) >= 6);
			gce_pkg::K_SCROLL_L: need_read = (32'(cx) + 6 < W);
			default: need_read = 1'b0;
		endcase
		if (cmd_q.kind == gce_pkg::K_TILE)
			last_px = (l_q == 4'd11) && (j_q == 3'd5);
		else
			last_px = (32'(x_q) == W - 1) && (32'(y_q) == H - 1);
	end

	always_comb begin
		rd_addr = row_base_q + gce_pkg::FB_AW'(sx);
		if (cmd_q.kind == gce_pkg::K_TILE)
			rd_addr = gce_pkg::FB_AW'(32'(cy) * W + 32'(cx));
		if (cmd_q.kind == gce_pkg::K_READ)
			rd_addr = gce_pkg::FB_AW'(32'(cmd_q.rd_y) * W + 32'(cmd_q.rd_x));
		if (cmd_q.kind == gce_pkg::K_TILE)
			wr_addr = gce_pkg::FB_AW'(32'(cy) * W + 32'(cx));
		else
			wr_addr = row_base_q + gce_pkg::FB_AW'(cx);
		case (cmd_q.kind)
			gce_pkg::K_TILE: wr_data = cmd_q.xor_mode ? (tile_c ^ fb_rd_q) : tile_c;
			gce_pkg::K_SCROLL_R, gce_pkg::K_SCROLL_L:
				wr_data = need_read ? fb_rd_q : cmd_q.color_a;
			default: wr_data = cmd_q.color_a;
		endcase
	end

	always_comb begin
		st_d = st_q;
		take = 1'b0;
		fb_re = 1'b0;
		fb_we = 1'b0;
		out_valid = (st_q == gce_pkg::B_OUT);
		case (st_q)
			gce_pkg::B_IDLE: if (q_valid) begin
				take = 1'b1;
				case (q_cmd.kind)
					gce_pkg::K_QUICK: st_d = gce_pkg::B_OUT;
					gce_pkg::K_READ: st_d = gce_pkg::B_RD;
					default: st_d = gce_pkg::B_RD;
				endcase
			end
			gce_pkg::B_RD: begin
				if (cmd_q.kind == gce_pkg::K_READ) begin
					fb_re = 1'b1;
					st_d = gce_pkg::B_READWAIT;
				end else begin
					fb_re = need_read;
					st_d = gce_pkg::B_WR;
				end
			end
			gce_pkg::B_WR: begin
				fb_we = (cmd_q.kind != gce_pkg::K_BORDER) || in_border;
				st_d = last_px ? gce_pkg::B_OUT : gce_pkg::B_RD;
			end
			gce_pkg::B_READWAIT: st_d = gce_pkg::B_OUT;
			gce_pkg::B_OUT: if (out_ready) st_d = gce_pkg::B_IDLE;
			default: st_d = gce_pkg::B_IDLE;
		endcase
	end
	assign q_pop = take;

	always_ff @(posedge clk) begin
		if (fb_re) fb_rd_q <= fb_mem[rd_addr];
		if (fb_we) fb_mem[wr_addr] <= wr_data;
	end

	// palette entry for the result is captured as the command is taken
	always_ff @(posedge clk) begin
		if (take && q_cmd.pal_we) pal_mem[q_cmd.pal_idx] <= q_cmd.pal_rgb;
		if (take) begin
			cmd_q <= q_cmd;
			pal_rd_q <= q_cmd.pal_we ? q_cmd.pal_rgb : pal_mem[q_cmd.pal_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= gce_pkg::B_IDLE;
			trans_q <= '0;
			x_q <= '0;
			y_q <= '0;
			l_q <= '0;
			j_q <= '0;
			row_base_q <= '0;
		end else begin
			st_q <= st_d;
			if (take) begin
				x_q <= '0;
				y_q <= '0;
				l_q <= '0;
				j_q <= '0;
				row_base_q <= '0;
				if (q_cmd.trans_we) trans_q <= q_cmd.color_a;
			end else if (st_q == gce_pkg::B_WR && !last_px) begin
				if (j_q == 3'd5) begin
					j_q <= '0;
					l_q <= l_q + 4'd1;
				end else begin
					j_q <= j_q + 3'd1;
				end
				if (32'(x_q) == W - 1) begin
					x_q <= '0;
					y_q <= y_q + gce_pkg::YW'(1);
					row_base_q <= row_base_q + gce_pkg::FB_AW'(W);
				end else begin
					x_q <= x_q + XWL'(1);
				end
			end
		end
	end

	always_comb begin
		st_r = cmd_q.status;
		pix_r = (cmd_q.kind == gce_pkg::K_READ && cmd_q.rd_ok) ? fb_rd_q : 4'd0;
		pal_r = (cmd_q.kind == gce_pkg::K_READ || cmd_q.pal_we) ? pal_rd_q : 12'd0;
	end
	assign status = st_r;
	assign pixel_color = pix_r;
	assign palette_red = pal_r[11:8];
	assign palette_green = pal_r[7:4];
	assign palette_blue = pal_r[3:0];
	assign transparent_index = trans_q;

`ifndef SYNTH
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> st_q == gce_pkg::B_IDLE) else $error("pop while busy");
	a_no_write_out: assert property (@(posedge clk) disable iff (!arst_n)
		fb_we |-> st_q == gce_pkg::B_WR) else $error("stray write");
	a_tile_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == gce_pkg::B_WR && cmd_q.kind == gce_pkg::K_TILE) |-> l_q < 4'd12)
		else $error("tile line overrun");
`endif
endmodule
`default_nettype wire
